/* src/pld_pkg.sv */
// ----------------------------------------------------------------------------
// pld_pkg
// shared types and constants for the piecewise-linear duty lookup
// ----------------------------------------------------------------------------
`default_nettype none

package pld_pkg;

    // field widths fixed by the beat layout
    localparam int CMD_W   = 1;
    localparam int SLOT_W  = 4;
    localparam int X_W     = 32;
    localparam int Y_W     = 16;
    localparam int CNT_W   = 5;
    localparam int PROD_W  = X_W + Y_W;      // 16 x 32 product
    localparam int SUM_W   = PROD_W + 1;     // sum of two products
    localparam int S_DATA_W = 88;            // 84 payload bits padded to bytes
    localparam int M_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

    localparam logic [Y_W-1:0] DUTY_MAX = 16'hFFFF;
    localparam logic [CNT_W-1:0] POINT_COUNT_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } pld_state_t;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [X_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* src/pld_table.sv */
// ----------------------------------------------------------------------------
// pld_table
// breakpoint store: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pld_table
    import pld_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [X_W-1:0]   wr_x,
    input  wire logic [Y_W-1:0]   wr_y,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [X_W-1:0]   rd_x,
    output logic      [Y_W-1:0]   rd_y
);

    logic [X_W-1:0] x_mem [DEPTH];
    logic [Y_W-1:0] y_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
    end

    always_ff @(posedge aclk) begin
        rd_x <= x_mem[rd_addr];
        rd_y <= y_mem[rd_addr];
    end

endmodule

`default_nettype wire

/* src/pld_div.sv */
// ----------------------------------------------------------------------------
// pld_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pld_div
    import pld_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [X_W-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [X_W-1:0]    dvs_reg, dvs_next;

    logic [X_W:0] trial;
    logic [X_W:0] diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits in X_W bits
            if (!diff[X_W]) begin
                rem_next = diff[X_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[X_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* src/piecewise_linear_duty_lookup.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_duty_lookup
// breakpoint table with linear interpolation from illuminance to duty
// ----------------------------------------------------------------------------
//
// channel   dir  tdata fields (lsb first)                      tuser
// s_        in   point_index, point_x, point_y, illuminance    command
// m_        out  duty                                          -
// cfg_      in   point_count (write only)                      -
//
// a write beat is written straight into the store; a lookup below the first
// point or at or past the last one goes from the scan to the output register,
// and one that interpolates reads one table entry per cycle in the scan, forms
// two products on the shared 16x32 multiplier, adds them, runs 49 quotient bits
// through the bit-serial divider and waits for its done flag, then loads the
// output register once that register is free
// s_tready is high only while the sequencer is idle; a finished duty waits
// in the output register, so writes are still taken while m_ stalls
// reset clears the sequencer, the output valid and point_count (to 16);
// the breakpoint store is not cleared and holds garbage until written
//
`default_nettype none

module piecewise_linear_duty_lookup
    import pld_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input beats
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [3:0] point_index, [35:4] point_x, [51:36] point_y,
    // [83:52] illuminance, [87:84] zero
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // [0] command
    input  wire logic                s_tuser,
    // result beats
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [15:0] duty
    output logic      [M_DATA_W-1:0] m_tdata,
    // point_count register
    input  wire logic                cfg_we,
    input  wire logic [CNT_W-1:0]    cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // payload unpack
    logic [SLOT_W-1:0] in_slot;
    logic [X_W-1:0]    in_x;
    logic [Y_W-1:0]    in_y;
    logic [X_W-1:0]    in_lux;

    assign in_slot = s_tdata[3:0];
    assign in_x    = s_tdata[35:4];
    assign in_y    = s_tdata[51:36];
    assign in_lux  = s_tdata[83:52];

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    // point_count register and the index of the last slot in use
    logic [CNT_W-1:0] point_count_reg;
    logic [IDX_W-1:0] last_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= POINT_COUNT_RESET;
        end else if (cfg_we) begin
            point_count_reg <= cfg_wdata;
        end
    end

    // zero acts as one, anything past the table acts as the full table
    always_comb begin
        if (point_count_reg == '0) begin
            last_idx = '0;
        end else if (32'(point_count_reg) > TABLE_DEPTH) begin
            last_idx = IDX_W'(TABLE_DEPTH - 1);
        end else begin
            last_idx = IDX_W'(point_count_reg - 1'b1);
        end
    end

    // breakpoint store
    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_rd_addr;
    logic [X_W-1:0]   tbl_rd_x;
    logic [Y_W-1:0]   tbl_rd_y;

    // slots past the table are dropped
    assign tbl_wr_en = s_fire && (s_tuser == CMD_WRITE) && (32'(in_slot) < TABLE_DEPTH);

    pld_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (IDX_W'(in_slot)),
        .wr_x    (in_x),
        .wr_y    (in_y),
        .rd_addr (tbl_rd_addr),
        .rd_x    (tbl_rd_x),
        .rd_y    (tbl_rd_y)
    );

    // divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    pld_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer and datapath registers
    pld_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [X_W-1:0]    lux_reg, lux_next;
    logic [X_W-1:0]    xlo_reg, xlo_next;
    logic [Y_W-1:0]    ylo_reg, ylo_next;
    logic [Y_W-1:0]    yup_reg, yup_next;
    logic [X_W-1:0]    d_up_reg, d_up_next;     // xup - lux
    logic [X_W-1:0]    d_lo_reg, d_lo_next;     // lux - xlo
    logic [X_W-1:0]    span_reg, span_next;     // xup - xlo
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [Y_W-1:0]    res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    logic [Y_W-1:0]    m_data_reg, m_data_next;

    // shared multiplier
    logic [Y_W-1:0]    mul_a;
    logic [X_W-1:0]    mul_b;
    logic [PROD_W-1:0] mul_p;

    assign mul_a = (state_reg == ST_MUL_LO) ? ylo_reg : yup_reg;
    assign mul_b = (state_reg == ST_MUL_LO) ? d_up_reg : d_lo_reg;
    assign mul_p = {{X_W{1'b0}}, mul_a} * {{Y_W{1'b0}}, mul_b};

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        lux_next     = lux_reg;
        xlo_next     = xlo_reg;
        ylo_next     = ylo_reg;
        yup_next     = yup_reg;
        d_up_next    = d_up_reg;
        d_lo_next    = d_lo_reg;
        span_next    = span_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        sum_next     = sum_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        tbl_rd_addr  = '0;
        div_req.start    = 1'b0;
        div_req.dividend = sum_reg;
        div_req.divisor  = span_reg;
        s_tready = (state_reg == ST_IDLE);

        // output register drains independently of the sequencer
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // slot 0 is read while idle, so it is ready on the first scan cycle
                tbl_rd_addr = '0;
                if (s_fire && (s_tuser == CMD_LOOKUP)) begin
                    lux_next   = in_lux;
                    k_next     = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // table data here is slot k
                tbl_rd_addr = k_reg;
                if (lux_reg < tbl_rd_x) begin
                    if (k_reg == '0) begin
                        // below the first breakpoint
                        res_next   = tbl_rd_y;
                        state_next = ST_OUT;
                    end else begin
                        yup_next   = tbl_rd_y;
                        d_up_next  = tbl_rd_x - lux_reg;
                        d_lo_next  = lux_reg - xlo_reg;
                        span_next  = tbl_rd_x - xlo_reg;
                        state_next = ST_MUL_LO;
                    end
                end else if (k_reg == last_idx) begin
                    // at or past the last counted breakpoint
                    res_next   = tbl_rd_y;
                    state_next = ST_OUT;
                end else begin
                    xlo_next    = tbl_rd_x;
                    ylo_next    = tbl_rd_y;
                    k_next      = k_reg + 1'b1;
                    tbl_rd_addr = k_reg + 1'b1;
                end
            end
            ST_MUL_LO: begin
                prod_next  = mul_p;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                acc_next   = prod_reg;
                prod_next  = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                sum_next = {1'b0, acc_reg} + {1'b0, prod_reg};
                if (span_reg == '0) begin
                    // zero span gives the upper y
                    res_next   = yup_reg;
                    state_next = ST_OUT;
                end else begin
                    // divider loads the fresh sum directly
                    div_req.start    = 1'b1;
                    div_req.dividend = sum_next;
                    state_next       = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient[SUM_W-1:X_W] != '0) begin
                        // quotient wider than 32 bits gives the upper y
                        res_next = yup_reg;
                    end else if (div_rsp.quotient[X_W-1:0] >=
                                 {{(X_W-Y_W){1'b0}}, DUTY_MAX}) begin
                        res_next = DUTY_MAX;
                    end else begin
                        res_next = div_rsp.quotient[Y_W-1:0];
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        k_reg      <= k_next;
        lux_reg    <= lux_next;
        xlo_reg    <= xlo_next;
        ylo_reg    <= ylo_next;
        yup_reg    <= yup_next;
        d_up_reg   <= d_up_next;
        d_lo_reg   <= d_lo_next;
        span_reg   <= span_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        sum_reg    <= sum_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* tb/tb_piecewise_linear_duty_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_duty_lookup
// self-checking bench: loads breakpoint tables, runs illuminance lookups,
// sweeps the point count and checks each duty against a bench table model
// ----------------------------------------------------------------------------
module tb_piecewise_linear_duty_lookup
    import pld_pkg::*;
();

    localparam int TABLE_DEPTH   = 16;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    // drain time after the last owed duty, meant to cover any beat in flight
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int IDLE_PCT      = 6;
    localparam int RANDOM_ROUNDS = 11;
    localparam int ROUND_ITEMS   = 21;
    localparam int PAD_W         = S_DATA_W - (SLOT_W + X_W + Y_W + X_W);

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    // [3:0] point_index, [35:4] point_x, [51:36] point_y,
    // [83:52] illuminance, [87:84] zero
    logic [S_DATA_W-1:0] s_tdata;
    // [0] command
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // [15:0] duty
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we;
    logic [CNT_W-1:0]    cfg_wdata;

    // bench copy of the breakpoint table and the point count
    logic [X_W-1:0]      bp_lux [TABLE_DEPTH];
    logic [Y_W-1:0]      bp_duty [TABLE_DEPTH];
    logic [CNT_W-1:0]    point_count_q;
    // duties still owed by the block, oldest first
    logic [Y_W-1:0]      duty_expected [$];

    int                  mismatches;
    int                  cycle_count = 0;
    // set during a stretch of rounds where neither side ever idles
    bit                  no_idle;

    piecewise_linear_duty_lookup #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial aclk = 1'b0;

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] duty check: %s", $time, what);
    endtask

    // expected duty for one illuminance against the current table
    function automatic logic [Y_W-1:0] interpolate_duty(input logic [X_W-1:0] lux);
        int             used;
        int             k;
        logic [X_W-1:0] x_lo, x_up, d_up, d_lo, span;
        logic [Y_W-1:0] y_lo, y_up;
        logic [63:0]    weighted, quo;
        logic [31:0]    q;
        used = point_count_q;
        if (used < 1) begin
            used = 1;
        end
        if (used > TABLE_DEPTH) begin
            used = TABLE_DEPTH;
        end
        // first breakpoint strictly above the illuminance
        k = 0;
        while (k < used && !(lux < bp_lux[k])) begin
            k++;
        end
        if (k >= used) begin
            return bp_duty[used-1];
        end
        if (k == 0) begin
            return bp_duty[0];
        end
        x_lo = bp_lux[k-1];
        x_up = bp_lux[k];
        y_lo = bp_duty[k-1];
        y_up = bp_duty[k];
        // differences wrap at 32 bits, products and sum are exact
        d_up = x_up - lux;
        d_lo = lux - x_lo;
        weighted = 64'(y_lo) * 64'(d_up) + 64'(y_up) * 64'(d_lo);
        span = x_up - x_lo;
        if (span == '0) begin
            return y_up;
        end
        quo = weighted / 64'(span);
        if (quo > 64'h0000_0000_FFFF_FFFF) begin
            q = 32'(y_up);
        end else begin
            q = quo[31:0];
        end
        if (q >= 32'(DUTY_MAX)) begin
            q = 32'(DUTY_MAX);
        end
        return q[Y_W-1:0];
    endfunction

    // receiver side: random backpressure, changed on the falling edge
    always @(negedge aclk) begin
        m_tready = no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each result beat with the oldest owed duty
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (duty_expected.size() == 0) begin
                report_mismatch($sformatf("duty %h arrived with nothing owed", m_tdata));
            end else begin
                if (m_tdata !== duty_expected[0]) begin
                    report_mismatch($sformatf("duty %h, model says %h",
                                              m_tdata, duty_expected[0]));
                end
                void'(duty_expected.pop_front());
            end
        end
    end

    // drive one input beat, hold it until taken, then update the model
    task automatic send_beat(input logic cmd, input logic [SLOT_W-1:0] slot,
                             input logic [X_W-1:0] px, input logic [Y_W-1:0] py,
                             input logic [X_W-1:0] lux);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {{PAD_W{1'b0}}, lux, py, px, slot};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_WRITE) begin
            if (int'(slot) < TABLE_DEPTH) begin
                bp_lux[slot]  = px;
                bp_duty[slot] = py;
            end
        end else begin
            duty_expected.push_back(interpolate_duty(lux));
        end
    endtask

    // unused fields of each beat carry random bits
    task automatic write_point(input logic [SLOT_W-1:0] slot, input logic [X_W-1:0] px,
                               input logic [Y_W-1:0] py);
        send_beat(CMD_WRITE, slot, px, py, $urandom());
    endtask

    task automatic look_up(input logic [X_W-1:0] lux);
        send_beat(CMD_LOOKUP, SLOT_W'($urandom()), $urandom(), Y_W'($urandom()), lux);
    endtask

    function automatic logic [Y_W-1:0] rand_duty();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            return '0;
        end
        if (pick == 1) begin
            return DUTY_MAX;
        end
        return Y_W'($urandom());
    endfunction

    // stop sending, wait for every owed duty, then let the sequencer drain
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (duty_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_point_count(input logic [CNT_W-1:0] value);
        settle();
        @(negedge aclk);
        cfg_we        = 1'b1;
        cfg_wdata     = value;
        point_count_q = value;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // small four-point table with breakpoints at the edges of the range
    task automatic test_directed();
        set_point_count(5'd4);
        write_point(4'd0, 32'h0000_0100, 16'h0000);
        write_point(4'd1, 32'h8000_0000, 16'hFFFF);
        write_point(4'd2, 32'hFFFF_FFF0, 16'h1234);
        write_point(4'd3, 32'hFFFF_FFFF, 16'hFFFF);
        // below the first point, on it, inside, on later points and on the last
        look_up(32'h0000_0000);
        look_up(32'h0000_00FF);
        look_up(32'h0000_0100);
        look_up(32'h4000_0000);
        look_up(32'h7FFF_FFFF);
        look_up(32'h8000_0000);
        look_up(32'hFFFF_FFF8);
        look_up(32'hFFFF_FFFE);
        look_up(32'hFFFF_FFFF);
        // both ends at full duty: the quotient lands on the clamp
        write_point(4'd0, 32'h0000_0100, 16'hFFFF);
        look_up(32'h1234_5678);
        // falling segment
        write_point(4'd1, 32'h8000_0000, 16'h0000);
        look_up(32'h4000_0000);
    endtask

    // fresh ascending tables with random content, then mostly lookups
    task automatic test_random_tables();
        int unsigned    xs [$];
        int unsigned    base;
        int             pick;
        int             seg;
        logic [X_W-1:0] lo, hi, lux;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            pick = $urandom_range(19);
            case (pick)
                0:       set_point_count(5'd1);
                1:       set_point_count(5'd16);
                2:       set_point_count(5'd0);
                3:       set_point_count(CNT_W'($urandom_range(17, 31)));
                default: set_point_count(CNT_W'($urandom_range(2, 16)));
            endcase
            no_idle = (round >= 4 && round < 7);
            // either spread over the whole range or packed tight with repeats
            xs = {};
            if ($urandom_range(1) == 0) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    xs.push_back($urandom());
                end
                xs.sort();
            end else begin
                base = $urandom_range(32'hFFFF_0000);
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    base += $urandom_range(40);
                    xs.push_back(base);
                end
            end
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                write_point(SLOT_W'(i), xs[i], rand_duty());
            end
            for (int i = 0; i < ROUND_ITEMS; i++) begin
                if ($urandom_range(99) < 10) begin
                    // stray write that may break the ordering
                    write_point(SLOT_W'($urandom()), $urandom(), rand_duty());
                end else begin
                    seg = $urandom_range(1, TABLE_DEPTH - 1);
                    lo  = bp_lux[seg-1];
                    hi  = bp_lux[seg];
                    pick = $urandom_range(9);
                    case (pick)
                        0, 1:    lux = bp_lux[$urandom_range(TABLE_DEPTH - 1)];
                        2:       lux = $urandom();
                        3:       lux = hi - 1;
                        default: lux = (hi > lo) ? lo + ($urandom() % (hi - lo)) : lo;
                    endcase
                    look_up(lux);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // count limits, including the values that clamp to one and to the depth
    task automatic test_point_count();
        logic [CNT_W-1:0] counts [5] = '{5'd1, 5'd0, 5'd16, 5'd17, 5'd31};
        for (int c = 0; c < 5; c++) begin
            set_point_count(counts[c]);
            look_up(32'h0000_0000);
            look_up(32'hFFFF_FFFF);
            look_up(bp_lux[0]);
            repeat (3) look_up($urandom());
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        mismatches    = 0;
        no_idle       = 1'b0;
        point_count_q = POINT_COUNT_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            bp_lux[i]  = '0;
            bp_duty[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_tables();
        test_point_count();
        settle();

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
